// File: src/mvt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvt_pkg
// Shared types and constants of the 4x4 vertex transform: item layouts,
// operation codes and the lane control group.
// ----------------------------------------------------------------------------
package mvt_pkg;

   // largest matrix side the item layout can carry
   localparam int SIDE = 4;

   typedef logic signed [31:0] elem_type;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_XFORM = 1'b1
   } op_type;

   typedef struct packed {
      op_type     operation;
      logic [1:0] row_index;
      elem_type   in_a;
      elem_type   in_b;
      elem_type   in_c;
      elem_type   in_d;
   } req_type;

   typedef struct packed {
      elem_type out_x;
      elem_type out_y;
      elem_type out_z;
      elem_type out_w;
      logic     saturated;
   } rsp_type;

   // load enables of the three lane pipeline stages
   typedef struct packed {
      logic en1;
      logic en2;
      logic en3;
   } stage_ctl_type;

endpackage

// File: src/mvt_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvt_lane
// One row dot product: registered products, registered pair sums with the
// rounding half, then final sum, arithmetic shift and 32-bit saturation.
// ----------------------------------------------------------------------------
module mvt_lane
   import mvt_pkg::*;
#(
   parameter int DIM       = 4,
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  stage_ctl_type            ctl,
   input  elem_type [DIM-1:0]       row_i,
   input  elem_type [DIM-1:0]       vec_i,
   output elem_type                 res_o,
   output logic                     clip_o
);

   // four 64-bit products plus the rounding half fit in 66 bits signed
   localparam int ACC_W = 66;
   localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC_BITS - 1);

   logic signed [63:0]      prod [SIDE];
   logic signed [ACC_W-1:0] pair0_ff;
   logic signed [ACC_W-1:0] pair1_ff;
   logic signed [ACC_W-1:0] total;
   logic signed [ACC_W-1:0] shifted;
   logic [ACC_W-32:0]       top_bits;
   elem_type                res_ff;
   elem_type                res_in;
   logic                    clip_ff;
   logic                    clip_in;

   for (genvar k = 0; k < SIDE; k++) begin : g_prod
      if (k < DIM) begin : g_used
         logic signed [63:0] p_ff;
         always_ff @(posedge clock) begin
            if (ctl.en1) begin
               p_ff <= 64'(signed'(row_i[k])) * 64'(signed'(vec_i[k]));
            end
         end
         assign prod[k] = p_ff;
      end else begin : g_unused
         assign prod[k] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en2) begin
         pair0_ff <= ACC_W'(prod[0]) + ACC_W'(prod[1]) + HALF;
         pair1_ff <= ACC_W'(prod[2]) + ACC_W'(prod[3]);
      end
   end

   always_comb begin
      total    = pair0_ff + pair1_ff;
      shifted  = total >>> FRAC_BITS;
      top_bits = shifted[ACC_W-1:31];
      clip_in  = (|top_bits) && !(&top_bits);
      if (!clip_in) begin
         res_in = shifted[31:0];
      end else if (shifted[ACC_W-1]) begin
         res_in = 32'sh8000_0000;
      end else begin
         res_in = 32'sh7fff_ffff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en3) begin
         res_ff  <= res_in;
         clip_ff <= clip_in;
      end
   end

   assign res_o  = res_ff;
   assign clip_o = clip_ff;

endmodule

// File: src/mvt_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvt_merge
// Gathers the lane results into one result item, folds the clip flags and
// holds the item in the output register until it is taken.
// ----------------------------------------------------------------------------
module mvt_merge
   import mvt_pkg::*;
#(
   parameter int DIM = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  elem_type [DIM-1:0]  lane_res,
   input  logic [DIM-1:0]      lane_clip,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp_data
);

   logic     valid_ff;
   rsp_type  data_ff;
   rsp_type  data_in;
   elem_type comp [SIDE];

   assign in_ready = !valid_ff || rsp_ready;

   // components beyond the matrix side read as zero
   for (genvar k = 0; k < SIDE; k++) begin : g_comp
      if (k < DIM) begin : g_used
         assign comp[k] = lane_res[k];
      end else begin : g_unused
         assign comp[k] = '0;
      end
   end

   always_comb begin
      data_in.out_x     = comp[0];
      data_in.out_y     = comp[1];
      data_in.out_z     = comp[2];
      data_in.out_w     = comp[3];
      data_in.saturated = |lane_clip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// File: src/mat4_vertex_transform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mat4_vertex_transform
// Holds a DIM x DIM fixed-point transform matrix (identity after reset) and
// multiplies incoming vectors by it, one lane per matrix row.
// ----------------------------------------------------------------------------
//  channel | ports                        | dir | content
//  --------+------------------------------+-----+-------------------------------
//  request | req_valid req_ready req_data | in  | row load or vector transform
//  result  | rsp_valid rsp_ready rsp_data | out | product vector, clip flag
//
//  one item per cycle while no stage stalls; a transform's result passes through the
//  products, pair sums, lane result and output register before it is valid;
//  loads give no item
//  a load takes effect at once: a transform in the very next cycle sees it
//  reset (synchronous) restores the identity matrix and empties the pipeline
//  stalls reach req_ready combinationally through every stage; an empty stage keeps req_ready high
// ----------------------------------------------------------------------------
module mat4_vertex_transform
   import mvt_pkg::*;
#(
   parameter int DIM       = 4,
   parameter int FRAC_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam logic [31:0] ONE_Q = 32'(1) << FRAC_BITS;

   elem_type [DIM-1:0] mat_ff [DIM];
   elem_type [SIDE-1:0] vec;
   elem_type [DIM-1:0]  lane_res;
   logic [DIM-1:0]      lane_clip;
   stage_ctl_type       ctl;
   logic                v1_ff;
   logic                v2_ff;
   logic                v3_ff;
   logic                en_out;
   logic                req_fire;

   assign vec      = {req_data.in_d, req_data.in_c, req_data.in_b, req_data.in_a};
   assign req_fire = req_valid && req_ready;

   assign ctl.en3   = !v3_ff || en_out;
   assign ctl.en2   = !v2_ff || ctl.en3;
   assign ctl.en1   = !v1_ff || ctl.en2;
   assign req_ready = ctl.en1;

   // matrix rows; rows beyond DIM are not stored, so such loads drop out
   for (genvar r = 0; r < DIM; r++) begin : g_row
      always_ff @(posedge clock) begin
         if (reset) begin
            for (int c = 0; c < DIM; c++) begin
               mat_ff[r][c] <= (c == r) ? ONE_Q : '0;
            end
         end else if (req_fire && req_data.operation == OP_LOAD
                      && req_data.row_index == 2'(r)) begin
            mat_ff[r] <= vec[DIM-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (ctl.en1) begin
            v1_ff <= req_fire && req_data.operation == OP_XFORM;
         end
         if (ctl.en2) begin
            v2_ff <= v1_ff;
         end
         if (ctl.en3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   for (genvar r = 0; r < DIM; r++) begin : g_lane
      mvt_lane #(
         .DIM       (DIM),
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .clock  (clock),
         .ctl    (ctl),
         .row_i  (mat_ff[r]),
         .vec_i  (vec[DIM-1:0]),
         .res_o  (lane_res[r]),
         .clip_o (lane_clip[r])
      );
   end

   mvt_merge #(
      .DIM (DIM)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v3_ff),
      .in_ready  (en_out),
      .lane_res  (lane_res),
      .lane_clip (lane_clip),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // a flagged item carries at least one component pinned at a range limit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated |->
         rsp_data.out_x == 32'sh7fff_ffff || rsp_data.out_x == 32'sh8000_0000 ||
         rsp_data.out_y == 32'sh7fff_ffff || rsp_data.out_y == 32'sh8000_0000 ||
         rsp_data.out_z == 32'sh7fff_ffff || rsp_data.out_z == 32'sh8000_0000 ||
         rsp_data.out_w == 32'sh7fff_ffff || rsp_data.out_w == 32'sh8000_0000)
      else $error("saturated flag without a clipped component");

   // input is refused only when every stage holds an item
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> v1_ff && v2_ff && v3_ff && rsp_valid)
      else $error("req_ready low with a free pipeline stage");

   // a new result item always comes out of the last lane stage
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(v3_ff))
      else $error("result item without a lane result behind it");

endmodule

// File: sim/mvt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvt_checker
// Watches both channels of the vertex transform, keeps its own copy of the
// matrix, works out the product for each transform item and compares every
// result field by field with the oldest expected product.
// ----------------------------------------------------------------------------
module mvt_checker
   import mvt_pkg::*;
#(
   parameter int DIM       = 4,
   parameter int FRAC_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending,
   output int      xform_count,
   output int      sat_count,
   output int      load_count
);

   localparam logic signed [67:0] LANE_MAX = 68'sh7FFFFFFF;
   localparam logic signed [67:0] LANE_MIN = -68'sh80000000;

   elem_type matrix [0:SIDE*SIDE-1];
   rsp_type  product_q [$];
   rsp_type  want_rsp;
   elem_type load_row [0:SIDE-1];
   string    lane_name [0:SIDE-1] = '{"x", "y", "z", "w"};

   function automatic elem_type lane_of(input rsp_type r, input int i);
      case (i)
         0:       return r.out_x;
         1:       return r.out_y;
         2:       return r.out_z;
         default: return r.out_w;
      endcase
   endfunction

   function automatic rsp_type transform_vector(input req_type item);
      elem_type           vec  [0:SIDE-1];
      elem_type           lane [0:SIDE-1];
      logic signed [67:0] acc;
      rsp_type            res;
      vec[0] = item.in_a;
      vec[1] = item.in_b;
      vec[2] = item.in_c;
      vec[3] = item.in_d;
      res.saturated = 1'b0;
      for (int r = 0; r < SIDE; r++) begin
         lane[r] = '0;
         if (r < DIM) begin
            // half added up front, then arithmetic shift: ties go upward
            acc = 68'sd1 <<< (FRAC_BITS - 1);
            for (int k = 0; k < DIM; k++) begin
               acc = acc + matrix[r*SIDE+k] * vec[k];
            end
            acc = acc >>> FRAC_BITS;
            if (acc > LANE_MAX) begin
               lane[r] = 32'sh7FFFFFFF;
               res.saturated = 1'b1;
            end else if (acc < LANE_MIN) begin
               lane[r] = 32'sh80000000;
               res.saturated = 1'b1;
            end else begin
               lane[r] = acc[31:0];
            end
         end
      end
      res.out_x = lane[0];
      res.out_y = lane[1];
      res.out_z = lane[2];
      res.out_w = lane[3];
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SIDE*SIDE; i++) begin
            matrix[i] = (i / SIDE == i % SIDE) ? (32'sd1 <<< FRAC_BITS) : '0;
         end
         product_q.delete();
         fail_count = 0;
         xform_count = 0;
         sat_count = 0;
         load_count = 0;
         pending <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (product_q.size() == 0) begin
               fail_count = fail_count + 1;
               $display("%0t: result with nothing expected: expected none, actual %h",
                        $time, rsp_data);
            end else begin
               want_rsp = product_q.pop_front();
               for (int i = 0; i < SIDE; i++) begin
                  if (lane_of(rsp_data, i) !== lane_of(want_rsp, i)) begin
                     fail_count = fail_count + 1;
                     $display("%0t: out_%s expected %h actual %h", $time, lane_name[i],
                              lane_of(want_rsp, i), lane_of(rsp_data, i));
                  end
               end
               if (rsp_data.saturated !== want_rsp.saturated) begin
                  fail_count = fail_count + 1;
                  $display("%0t: saturated expected %b actual %b", $time,
                           want_rsp.saturated, rsp_data.saturated);
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_data.operation == OP_XFORM) begin
               want_rsp = transform_vector(req_data);
               product_q.push_back(want_rsp);
               xform_count = xform_count + 1;
               if (want_rsp.saturated) sat_count = sat_count + 1;
            end else if (req_data.row_index < DIM) begin
               load_row[0] = req_data.in_a;
               load_row[1] = req_data.in_b;
               load_row[2] = req_data.in_c;
               load_row[3] = req_data.in_d;
               for (int c = 0; c < DIM; c++) begin
                  matrix[req_data.row_index*SIDE+c] = load_row[c];
               end
               load_count = load_count + 1;
            end
         end
         pending <= product_q.size();
      end
   end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives row loads and vector transforms into the vertex transform, with
// random stalls on both channels, a calm stretch and a mid-run drain; the
// checker beside the block predicts every product and counts mismatches.
// ----------------------------------------------------------------------------
module tb_top;
   import mvt_pkg::*;

   localparam int       DIM          = 4;
   localparam int       FRAC_BITS    = 16;
   localparam int       RANDOM_ITEMS = 1700;
   localparam int       STALL_LIMIT  = 1000;
   localparam elem_type ONE          = 32'sh00010000;
   localparam elem_type E_MAX        = 32'sh7FFFFFFF;
   localparam elem_type E_MIN        = 32'sh80000000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    calm = 1'b0;

   int fail_count;
   int pending;
   int xform_count;
   int sat_count;
   int load_count;
   int stall_cycles = 0;

   mat4_vertex_transform #(
      .DIM       (DIM),
      .FRAC_BITS (FRAC_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   mvt_checker #(
      .DIM       (DIM),
      .FRAC_BITS (FRAC_BITS)
   ) u_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .pending     (pending),
      .xform_count (xform_count),
      .sat_count   (sat_count),
      .load_count  (load_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // result side stalls about a quarter of the time unless calm
   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 26);
   end

   initial begin
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles = stall_cycles + 1;
         end
      end
      $display("mat4_vertex_transform: mismatch");
      $finish;
   end

   function automatic req_type make_item(input op_type op, input logic [1:0] row,
                                         input elem_type a, input elem_type b,
                                         input elem_type c, input elem_type d);
      req_type item;
      item.operation = op;
      item.row_index = row;
      item.in_a = a;
      item.in_b = b;
      item.in_c = c;
      item.in_d = d;
      return item;
   endfunction

   // mostly small values (within +-4.0), with extremes and raw noise mixed in
   function automatic elem_type rand_elem();
      case ($urandom_range(9))
         0:       return E_MIN;
         1:       return E_MAX;
         2, 3:    return $urandom;
         default: return elem_type'($urandom_range(524288)) - 32'sd262144;
      endcase
   endfunction

   function automatic req_type rand_item();
      op_type op;
      op = ($urandom_range(99) < 30) ? OP_LOAD : OP_XFORM;
      return make_item(op, 2'($urandom_range(3)), rand_elem(), rand_elem(),
                       rand_elem(), rand_elem());
   endfunction

   task automatic send_item(input req_type item);
      if (!calm) begin
         while ($urandom_range(99) < 26) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // hold the sender off until every expected result is back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // identity matrix passes vectors through untouched
      send_item(make_item(OP_XFORM, 2'd3, 32'sh00018000, 32'shFFFE0000, E_MAX, E_MIN));
      send_item(make_item(OP_XFORM, 2'd0, 0, 0, 0, 0));
      send_item(make_item(OP_LOAD, 2'd0, 1, 0, 0, 0));
      send_item(make_item(OP_LOAD, 2'd1, -1, 0, 0, 0));
      send_item(make_item(OP_LOAD, 2'd2, E_MAX, E_MAX, E_MAX, E_MAX));
      send_item(make_item(OP_LOAD, 2'd3, E_MIN, E_MIN, E_MIN, E_MIN));
      // exact halves on rows 0 and 1 round upward
      send_item(make_item(OP_XFORM, 2'd1, 32'sh8000, 0, 0, 0));
      send_item(make_item(OP_XFORM, 2'd2, -32'sh8000, 0, 0, 0));
      send_item(make_item(OP_XFORM, 2'd0, 32'sh7FFF, 32'sh8001, 0, 0));
      // clipping both ways, and min*min summed four times
      send_item(make_item(OP_XFORM, 2'd3, E_MAX, E_MAX, E_MAX, E_MAX));
      send_item(make_item(OP_XFORM, 2'd1, E_MIN, E_MIN, E_MIN, E_MIN));
      send_item(make_item(OP_XFORM, 2'd2, E_MAX, E_MIN, E_MAX, E_MIN));
      send_item(make_item(OP_LOAD, 2'd0, E_MIN, E_MAX, 0, -1));
      send_item(make_item(OP_XFORM, 2'd0, E_MIN, E_MIN, 1, -1));
      send_item(make_item(OP_LOAD, 2'd0, 2 * ONE, 0, 0, 0));
      send_item(make_item(OP_LOAD, 2'd1, 0, ONE, 0, 0));
      send_item(make_item(OP_LOAD, 2'd2, 0, 0, -ONE, 0));
      send_item(make_item(OP_LOAD, 2'd3, 32'sh8000, 32'sh8000, 32'sh8000, 32'sh8000));
      send_item(make_item(OP_XFORM, 2'd3, 32'sh00034000, -ONE, 32'sh8000, 2 * ONE));
      send_item(make_item(OP_XFORM, 2'd1, 1, 1, 1, 1));
      send_item(make_item(OP_XFORM, 2'd2, -1, -1, -1, -1));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 600) drain();
         if (n == 900) calm <= 1'b1;
         if (n == 1250) calm <= 1'b0;
         send_item(rand_item());
      end
      drain();
      repeat (8) @(posedge clock);

      $display("covered %0d row loads and %0d transforms, %0d of them clipping,",
               load_count, xform_count, sat_count);
      $display("with random stalls on both channels, a stall-free stretch and a mid-run drain");
      if (fail_count == 0) begin
         $display("mat4_vertex_transform: match");
      end else begin
         $display("mat4_vertex_transform: mismatch");
      end
      $finish;
   end

endmodule
